/* sv/erms_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// erms_pkg
// shared types, constants and the control store of the rms level block
// ----------------------------------------------------------------------------
package erms_pkg;

    localparam int SAMPLE_BITS_DEF      = 16;
    localparam int WEIGHT_FRAC_BITS_DEF = 16;
    localparam int MEAN_FRAC_BITS       = 16;
    localparam int WEIGHT_RESET         = 655;
    localparam int OUT_BITS             = 16;
    localparam logic [OUT_BITS-1:0] OUT_MAX = 16'hFFFF;

    localparam int STEP_BITS = 4;

    // control store addresses
    localparam logic [STEP_BITS-1:0] STEP_IDLE      = 4'd0;
    localparam logic [STEP_BITS-1:0] STEP_SQUARE    = 4'd1;
    localparam logic [STEP_BITS-1:0] STEP_DIFF      = 4'd2;
    localparam logic [STEP_BITS-1:0] STEP_MUL_LO    = 4'd3;
    localparam logic [STEP_BITS-1:0] STEP_MUL_HI    = 4'd4;
    localparam logic [STEP_BITS-1:0] STEP_UPDATE    = 4'd5;
    localparam logic [STEP_BITS-1:0] STEP_ROOT_INIT = 4'd6;
    localparam logic [STEP_BITS-1:0] STEP_ROOT_STEP = 4'd7;
    localparam logic [STEP_BITS-1:0] STEP_EMIT      = 4'd8;

    // sequencing condition of a control word
    typedef enum logic [1:0] {
        C_NEXT     = 2'd0,
        C_WAIT_IN  = 2'd1,
        C_LOOP     = 2'd2,
        C_WAIT_OUT = 2'd3
    } t_cond;

    // datapath enables
    typedef struct packed {
        logic ld_sample;
        logic ld_square;
        logic ld_diff;
        logic mul_lo;
        logic mul_hi;
        logic upd_mean;
        logic root_init;
        logic root_step;
        logic emit;
    } t_dp_ctrl;

    // datapath status back to the sequencer
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

    typedef struct packed {
        t_dp_ctrl              ctl;
        t_cond                 cond;
        logic [STEP_BITS-1:0]  target;
        logic                  ld_count;
    } t_ucode;

    function automatic t_ucode ucode_rom(input logic [STEP_BITS-1:0] addr);
        t_ucode w;
        w = '0;
        w.cond   = C_NEXT;
        w.target = STEP_IDLE;
        unique case (addr)
            STEP_IDLE: begin
                w.ctl.ld_sample = 1'b1;
                w.cond          = C_WAIT_IN;
            end
            STEP_SQUARE:    w.ctl.ld_square = 1'b1;
            STEP_DIFF:      w.ctl.ld_diff   = 1'b1;
            STEP_MUL_LO:    w.ctl.mul_lo    = 1'b1;
            STEP_MUL_HI:    w.ctl.mul_hi    = 1'b1;
            STEP_UPDATE:    w.ctl.upd_mean  = 1'b1;
            STEP_ROOT_INIT: begin
                w.ctl.root_init = 1'b1;
                w.ld_count      = 1'b1;
            end
            STEP_ROOT_STEP: begin
                w.ctl.root_step = 1'b1;
                w.cond          = C_LOOP;
                w.target        = STEP_ROOT_STEP;
            end
            STEP_EMIT: begin
                w.ctl.emit = 1'b1;
                w.cond     = C_WAIT_OUT;
                w.target   = STEP_IDLE;
            end
            default: begin
                // unused addresses fall back to idle
                w.cond   = C_WAIT_OUT;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

/* sv/erms_useq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// erms_useq
// step counter, loop counter and control store of the rms level block
// ----------------------------------------------------------------------------
module erms_useq #(
    parameter int SAMPLE_BITS = erms_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  erms_pkg::t_dp_stat  i_stat,
    output erms_pkg::t_dp_ctrl  o_ctl
);
    import erms_pkg::*;

    localparam int CW = $clog2(SAMPLE_BITS);

    logic [STEP_BITS-1:0] r_pc,    n_pc;
    logic [CW-1:0]        r_count, n_count;
    t_ucode               word;
    logic                 fire;

    assign word       = ucode_rom(r_pc);
    assign o_in_ready = (word.cond == C_WAIT_IN);

    always_comb begin
        fire    = 1'b1;
        n_pc    = r_pc + 4'd1;
        n_count = r_count;
        unique case (word.cond)
            C_NEXT: begin
            end
            C_WAIT_IN: begin
                fire = i_in_valid;
                if (!i_in_valid) begin
                    n_pc = r_pc;
                end
            end
            C_LOOP: begin
                if (r_count != '0) begin
                    n_pc    = word.target;
                    n_count = r_count - 1'b1;
                end
            end
            C_WAIT_OUT: begin
                fire = i_stat.out_free;
                n_pc = i_stat.out_free ? word.target : r_pc;
            end
        endcase
        if (word.ld_count) begin
            n_count = CW'(SAMPLE_BITS - 1);
        end
    end

    assign o_ctl = fire ? word.ctl : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= STEP_IDLE;
            r_count <= '0;
        end else begin
            r_pc    <= n_pc;
            r_count <= n_count;
        end
    end

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= STEP_EMIT)
        else $error("step counter left the program");

    a_loop_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == STEP_EMIT) |-> (r_count == '0))
        else $error("root loop left with iterations pending");

endmodule
`default_nettype wire

/* sv/erms_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// erms_datapath
// square, smoothing update, bit-serial root and output register
// ----------------------------------------------------------------------------
module erms_datapath #(
    parameter int SAMPLE_BITS      = erms_pkg::SAMPLE_BITS_DEF,
    parameter int WEIGHT_FRAC_BITS = erms_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  erms_pkg::t_dp_ctrl                 i_ctl,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic [WEIGHT_FRAC_BITS-1:0]   i_weight,
    output erms_pkg::t_dp_stat                 o_stat,
    output logic                               o_rms_valid,
    input  wire logic                          i_rms_ready,
    output logic [erms_pkg::OUT_BITS-1:0]      o_rms_level
);
    import erms_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int W  = WEIGHT_FRAC_BITS;
    localparam int SQ = 2 * SB;
    localparam int MW = SQ + MEAN_FRAC_BITS;
    localparam int PW = MW + W;
    localparam int MA = (SB > W) ? SB : W;

    logic [SB-1:0]   r_mag;
    logic [MW-1:0]   r_square;
    logic [MW-1:0]   r_mean;
    logic [MW-1:0]   r_diff;
    logic            r_ge;
    logic [PW-1:0]   r_acc;
    logic [SQ-1:0]   r_rad;
    logic [SB+1:0]   r_rem;
    logic [SB-1:0]   r_root;
    logic            r_out_valid;
    logic [OUT_BITS-1:0] r_level;

    logic [SB-1:0]   mag;
    logic [MA-1:0]   mul_a;
    logic [31:0]     mul_b;
    logic [MA+31:0]  prod;
    logic [63:0]     diff_ext;
    logic [PW+31:0]  hi_term;
    logic [MW-1:0]   step;
    logic [SB+3:0]   rem_sh;
    logic [SB+3:0]   trial;
    logic [SB+3:0]   rem_new;
    logic            take;
    logic [31:0]     root_ext;
    logic            out_free;

    // magnitude; the most negative code maps onto itself as unsigned
    assign mag = i_sample[SB-1] ? (~i_sample + 1'b1) : i_sample;

    // one shared multiplier: square, then weight times each diff half
    assign diff_ext = 64'(r_diff);
    assign mul_a    = i_ctl.ld_square ? MA'(r_mag) : MA'(i_weight);
    assign mul_b    = i_ctl.ld_square ? 32'(r_mag)
                    : (i_ctl.mul_hi ? diff_ext[63:32] : diff_ext[31:0]);
    assign prod     = (MA+32)'(mul_a) * (MA+32)'(mul_b);
    assign hi_term  = {PW'(prod), 32'b0};
    assign step     = r_acc[PW-1:W];

    // restoring root, one result bit per step
    assign rem_sh  = {r_rem, r_rad[SQ-1 -: 2]};
    assign trial   = {2'b00, r_root, 2'b01};
    assign take    = (rem_sh >= trial);
    assign rem_new = take ? (rem_sh - trial) : rem_sh;

    assign root_ext = 32'(r_root);
    assign out_free = !r_out_valid || i_rms_ready;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_sample) begin
            r_mag <= mag;
        end
        if (i_ctl.ld_square) begin
            r_square <= {prod[SQ-1:0], {MEAN_FRAC_BITS{1'b0}}};
        end
        if (i_ctl.ld_diff) begin
            r_ge   <= (r_square >= r_mean);
            r_diff <= (r_square >= r_mean) ? (r_square - r_mean) : (r_mean - r_square);
        end
        if (i_ctl.mul_lo) begin
            r_acc <= PW'(prod);
        end
        if (i_ctl.mul_hi) begin
            r_acc <= r_acc + hi_term[PW-1:0];
        end
        if (i_ctl.root_init) begin
            r_rad  <= r_mean[MW-1:MEAN_FRAC_BITS];
            r_rem  <= '0;
            r_root <= '0;
        end
        if (i_ctl.root_step) begin
            r_rad  <= {r_rad[SQ-3:0], 2'b00};
            r_rem  <= rem_new[SB+1:0];
            r_root <= {r_root[SB-2:0], take};
        end
        if (i_ctl.emit) begin
            // saturate roots above the output range
            r_level <= (root_ext > 32'(OUT_MAX)) ? OUT_MAX : root_ext[OUT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.upd_mean) begin
                r_mean <= r_ge ? (r_mean + step) : (r_mean - step);
            end
            if (i_ctl.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_rms_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.out_free = out_free;
    assign o_rms_valid     = r_out_valid;
    assign o_rms_level     = r_level;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.emit |-> out_free)
        else $error("result written over an untaken result");

    a_mean_between: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.upd_mean |=>
            ($past(r_ge) ? (r_mean >= $past(r_mean) && r_mean <= r_square)
                         : (r_mean <= $past(r_mean) && r_mean >= r_square)))
        else $error("mean left the range between old mean and square");

endmodule
`default_nettype wire

/* sv/exponential_rms_level.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// exponential_rms_level
// exponentially smoothed rms level of a signed sample stream
// ----------------------------------------------------------------------------
// usage
//   sample channel: i_sample_valid / o_sample_ready, one signed sample per
//   transfer. rms channel: o_rms_valid / i_rms_ready, one level per sample.
//   config channel: i_cfg_valid / o_cfg_ready carries the smoothing weight
//   (q0.WEIGHT_FRAC_BITS); always ready, write it only while idle.
// sequence
//   the next sample is taken only once the current result has been written
//   to the output register, so samples do not overlap. the control program
//   runs one step to take the sample, five steps for square and smoothing
//   on the shared multiplier, one step to set up the root, one step per root
//   bit in the bit-serial square root loop, one step to write the output
//   register.
// reset
//   mean square cleared, weight back to 655, output register empty.
// stall
//   a waiting result sits in the output register while the next sample
//   is accepted and processed; the program holds at its last step until
//   the output register is free.
// ----------------------------------------------------------------------------
module exponential_rms_level #(
    parameter int SAMPLE_BITS      = erms_pkg::SAMPLE_BITS_DEF,
    parameter int WEIGHT_FRAC_BITS = erms_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // sample channel
    input  wire logic                          i_sample_valid,
    output logic                               o_sample_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    // result channel
    output logic                               o_rms_valid,
    input  wire logic                          i_rms_ready,
    output logic [erms_pkg::OUT_BITS-1:0]      o_rms_level,
    // config channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [WEIGHT_FRAC_BITS-1:0]   i_cfg_smoothing_weight
);
    import erms_pkg::*;

    logic [WEIGHT_FRAC_BITS-1:0] r_weight;
    t_dp_ctrl                    ctl;
    t_dp_stat                    stat;

    // weight register, written on every config transfer
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= WEIGHT_FRAC_BITS'(WEIGHT_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_weight <= i_cfg_smoothing_weight;
        end
    end

    // sequencer: step counter walks the control store
    erms_useq #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample_valid),
        .o_in_ready (o_sample_ready),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    // datapath: shared multiplier, mean register, root unit, output register
    erms_datapath #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_sample    (i_sample),
        .i_weight    (r_weight),
        .o_stat      (stat),
        .o_rms_valid (o_rms_valid),
        .i_rms_ready (i_rms_ready),
        .o_rms_level (o_rms_level)
    );

endmodule
`default_nettype wire
